// ===== src/tte_pkg.sv =====
// Package for the timer table engine: sizes, mode and status codes, FSM states.
// Depends on nothing; the interfaces, the engine and the testbench import it.
package tte_pkg;
	localparam int NUM_TIMERS = 64;
	localparam int IDX_W      = $clog2(NUM_TIMERS);
	localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
	localparam int FIELD_IW   = 6;
	localparam int TICK_W     = 64;
	localparam logic [TICK_W-1:0] TICK_NONE = '1;

	typedef enum logic [2:0] {
		MODE_TICK   = 3'd0,
		MODE_ALLOC  = 3'd1,
		MODE_FREE   = 3'd2,
		MODE_ARM    = 3'd3,
		MODE_REARM  = 3'd4,
		MODE_CANCEL = 3'd5,
		MODE_EXPIRE = 3'd6,
		MODE_NONE   = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_BAD_INDEX    = 3'd1,
		ST_WRONG_STATE  = 3'd2,
		ST_BAD_TICK     = 3'd3,
		ST_NONE_FREE    = 3'd4,
		ST_TICK_IGNORED = 3'd5,
		ST_EXPIRED      = 3'd6,
		ST_NONE_DUE     = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SREAD,
		S_SCHK,
		S_SFIN
	} state_t;
endpackage

// ===== src/tte_in_if.sv =====
// Request channel of the timer table engine: valid, ready and one command item.
// Depends on tte_pkg.
interface tte_in_if import tte_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [2:0]          mode;
	logic [FIELD_IW-1:0] timer_index;
	logic [TICK_W-1:0]   tick_value;

	modport source (output valid, mode, timer_index, tick_value, input ready);
	modport sink   (input valid, mode, timer_index, tick_value, output ready);
endinterface

// ===== src/tte_out_if.sv =====
// Result channel of the timer table engine: valid, ready and one result item.
// Depends on tte_pkg.
interface tte_out_if import tte_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [2:0]          status;
	logic [FIELD_IW-1:0] timer_index_out;
	logic [TICK_W-1:0]   expiry_out;
	logic                last;

	modport source (output valid, status, timer_index_out, expiry_out, last, input ready);
	modport sink   (input valid, status, timer_index_out, expiry_out, last, output ready);
endinterface

// ===== src/tte_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module tte_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== src/timer_table_engine.sv =====
// Timer table engine: expiry and free-list link memories, allocation flags and FSM.
// A table operation is latched into the command registers, executed in S_EXEC and its
// result is registered for rsp; a new item is taken only in S_IDLE, after the last one.
// Expire reads then checks the expiry RAM for each slot below the watermark (S_SREAD,
// S_SCHK), then ends in S_SFIN. Reset clears all control state at once; memories need no
// clearing pass, the watermark bounds which entries are ever used. Depends on tte_pkg, interfaces, tte_ram.
module timer_table_engine import tte_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	tte_in_if.sink  req,
	tte_out_if.source rsp
);
	state_t state_q, state_d;

	mode_t               mode_q;
	logic [FIELD_IW-1:0] idx_q;
	logic [TICK_W-1:0]   tick_q;

	logic [NUM_TIMERS-1:0] alloc_q;
	logic [CNT_W-1:0]      free_head_q;
	logic [CNT_W-1:0]      watermark_q;
	logic [TICK_W-1:0]     cur_tick_q;
	logic [TICK_W-1:0]     earliest_q;

	logic [CNT_W-1:0]  scan_q;
	logic [TICK_W-1:0] soonest_q;
	logic              pend_valid_q;
	logic [IDX_W-1:0]  pend_idx_q;
	logic [TICK_W-1:0] pend_exp_q;

	logic                out_valid_q;
	logic [2:0]          out_status_q;
	logic [FIELD_IW-1:0] out_idx_q;
	logic [TICK_W-1:0]   out_exp_q;
	logic                out_last_q;

	// memory ports
	logic              exp_we, exp_re, nf_we, nf_re;
	logic [IDX_W-1:0]  exp_waddr, exp_raddr, nf_waddr;
	logic [TICK_W-1:0] exp_wdata, exp_rd;
	logic [CNT_W-1:0]  nf_wdata, nf_rd;

	logic accept, out_free;
	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);

	tte_ram #(.DEPTH(NUM_TIMERS), .WIDTH(TICK_W)) u_exp_ram (
		.clk(clk), .we(exp_we), .waddr(exp_waddr), .wdata(exp_wdata),
		.re(exp_re), .raddr(exp_raddr), .rdata(exp_rd)
	);

	tte_ram #(.DEPTH(NUM_TIMERS), .WIDTH(CNT_W)) u_nf_ram (
		.clk(clk), .we(nf_we), .waddr(nf_waddr), .wdata(nf_wdata),
		.re(nf_re), .raddr(free_head_q[IDX_W-1:0]), .rdata(nf_rd)
	);

	// decoded operation
	logic              emit, fire, emit_last;
	status_t           emit_status;
	logic [FIELD_IW-1:0] emit_idx;
	logic [TICK_W-1:0] emit_exp;
	logic              slot_ok, active, due, head_fresh;
	logic              cur_we, earliest_we, alloc_set, alloc_clr, head_we, wm_we;
	logic              scan_start, scan_step, pend_load, fin;
	logic [TICK_W-1:0] earliest_new;
	logic [CNT_W-1:0]  head_new, wm_new, scan_next;

	assign slot_ok    = (FIELD_IW + 1)'(idx_q) < (FIELD_IW + 1)'(watermark_q);
	assign active     = exp_rd != TICK_NONE;
	assign due        = exp_rd <= cur_tick_q;
	assign head_fresh = free_head_q >= watermark_q;
	assign scan_next  = scan_q + CNT_W'(1);

	always_comb begin
		exp_re = 1'b0;
		nf_re = 1'b0;
		exp_raddr = req.timer_index[IDX_W-1:0];
		exp_we = 1'b0;
		exp_waddr = idx_q[IDX_W-1:0];
		exp_wdata = TICK_NONE;
		nf_we = 1'b0;
		nf_waddr = idx_q[IDX_W-1:0];
		nf_wdata = free_head_q;
		emit = 1'b0;
		emit_status = ST_OK;
		emit_idx = '0;
		emit_exp = '0;
		emit_last = 1'b1;
		fire = 1'b1;
		cur_we = 1'b0;
		earliest_we = 1'b0;
		earliest_new = tick_q;
		alloc_set = 1'b0;
		alloc_clr = 1'b0;
		head_we = 1'b0;
		head_new = CNT_W'(idx_q);
		wm_we = 1'b0;
		wm_new = free_head_q + CNT_W'(1);
		scan_start = 1'b0;
		scan_step = 1'b0;
		pend_load = 1'b0;
		fin = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				exp_re = accept;
				nf_re = accept;
				if (mode_t'(req.mode) == MODE_ALLOC) begin
					exp_raddr = free_head_q[IDX_W-1:0];
				end
			end
			S_EXEC: begin
				emit = 1'b1;
				fire = out_free;
				case (mode_q)
					MODE_TICK: begin
						if (tick_q == TICK_NONE) begin
							emit_status = ST_BAD_TICK;
						end else if (tick_q <= cur_tick_q) begin
							emit_status = ST_TICK_IGNORED;
						end else begin
							cur_we = fire;
						end
					end
					MODE_ALLOC: begin
						if (free_head_q == CNT_W'(NUM_TIMERS)) begin
							emit_status = ST_NONE_FREE;
						end else begin
							emit_idx = FIELD_IW'(free_head_q);
							exp_we = fire;
							exp_waddr = free_head_q[IDX_W-1:0];
							alloc_set = fire;
							head_we = fire;
							// a slot never freed still links to its successor
							head_new = head_fresh ? free_head_q + CNT_W'(1) : nf_rd;
							wm_we = fire && head_fresh;
						end
					end
					MODE_FREE: begin
						if (!slot_ok) begin
							emit_status = ST_BAD_INDEX;
						end else if (!alloc_q[idx_q[IDX_W-1:0]] || active) begin
							emit_status = ST_WRONG_STATE;
						end else begin
							nf_we = fire;
							head_we = fire;
							alloc_clr = fire;
						end
					end
					MODE_ARM, MODE_REARM: begin
						if (tick_q == TICK_NONE) begin
							emit_status = ST_BAD_TICK;
						end else if (!slot_ok) begin
							emit_status = ST_BAD_INDEX;
						end else if (active != (mode_q == MODE_REARM)) begin
							emit_status = ST_WRONG_STATE;
						end else begin
							exp_we = fire;
							exp_wdata = tick_q;
							earliest_we = fire && (tick_q < earliest_q);
						end
					end
					MODE_CANCEL: begin
						if (!slot_ok) begin
							emit_status = ST_BAD_INDEX;
						end else if (!active) begin
							emit_status = ST_WRONG_STATE;
						end else begin
							exp_we = fire;
						end
					end
					MODE_EXPIRE: begin
						if (earliest_q > cur_tick_q) begin
							emit_status = ST_NONE_DUE;
						end else begin
							emit = 1'b0;
							fire = 1'b1;
							scan_start = 1'b1;
						end
					end
					default: begin
						emit = 1'b0;
						fire = 1'b1;
					end
				endcase
			end
			S_SREAD: begin
				exp_re = 1'b1;
				exp_raddr = scan_q[IDX_W-1:0];
			end
			S_SCHK: begin
				if (due) begin
					// hand out the held item; keep this one until the next is known
					emit = pend_valid_q;
					emit_status = ST_EXPIRED;
					emit_idx = FIELD_IW'(pend_idx_q);
					emit_exp = pend_exp_q;
					emit_last = 1'b0;
					fire = !pend_valid_q || out_free;
					exp_we = fire;
					exp_waddr = scan_q[IDX_W-1:0];
					pend_load = fire;
				end
				scan_step = fire;
			end
			S_SFIN: begin
				emit = 1'b1;
				fire = out_free;
				fin = fire;
				earliest_we = fire;
				earliest_new = soonest_q;
				if (pend_valid_q) begin
					emit_status = ST_EXPIRED;
					emit_idx = FIELD_IW'(pend_idx_q);
					emit_exp = pend_exp_q;
				end else begin
					emit_status = ST_NONE_DUE;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (accept) state_d = S_EXEC;
			S_EXEC: begin
				if (scan_start) begin
					state_d = (watermark_q == '0) ? S_SFIN : S_SREAD;
				end else if (fire) begin
					state_d = S_IDLE;
				end
			end
			S_SREAD: state_d = S_SCHK;
			S_SCHK: begin
				if (scan_step) begin
					state_d = (scan_next == watermark_q) ? S_SFIN : S_SREAD;
				end
			end
			S_SFIN:  if (fire) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			alloc_q <= '0;
			free_head_q <= '0;
			watermark_q <= '0;
			cur_tick_q <= '0;
			earliest_q <= TICK_NONE;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cur_we) cur_tick_q <= tick_q;
			if (earliest_we) earliest_q <= earliest_new;
			if (alloc_set) alloc_q[free_head_q[IDX_W-1:0]] <= 1'b1;
			if (alloc_clr) alloc_q[idx_q[IDX_W-1:0]] <= 1'b0;
			if (head_we) free_head_q <= head_new;
			if (wm_we) watermark_q <= wm_new;
			if (scan_start || fin) pend_valid_q <= 1'b0;
			else if (pend_load) pend_valid_q <= 1'b1;
			if (emit && fire) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(req.mode);
			idx_q <= req.timer_index;
			tick_q <= req.tick_value;
		end
		if (scan_start) begin
			scan_q <= '0;
			soonest_q <= TICK_NONE;
		end else if (scan_step) begin
			scan_q <= scan_next;
			if (!due && exp_rd < soonest_q) soonest_q <= exp_rd;
		end
		if (pend_load) begin
			pend_idx_q <= scan_q[IDX_W-1:0];
			pend_exp_q <= exp_rd;
		end
		if (emit && fire) begin
			out_status_q <= emit_status;
			out_idx_q <= emit_idx;
			out_exp_q <= emit_exp;
			out_last_q <= emit_last;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.timer_index_out = out_idx_q;
	assign rsp.expiry_out = out_exp_q;
	assign rsp.last = out_last_q;

	a_wm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		watermark_q <= CNT_W'(NUM_TIMERS) && free_head_q <= CNT_W'(NUM_TIMERS))
		else $error("watermark or free head out of range");

	a_expired_due: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_EXPIRED |-> rsp.expiry_out <= cur_tick_q)
		else $error("expired item not due");

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |=> out_valid_q)
		else $error("pending result dropped");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SREAD |-> scan_q < watermark_q)
		else $error("scan beyond watermark");
endmodule

// ===== bench/timer_table_engine_tb.sv =====
// Testbench for the timer table engine: random and directed command items,
// results checked in order against a table predictor. Depends on tte_pkg, the interfaces and the engine.
`timescale 1ns / 100ps

module timer_table_engine_tb;
	import tte_pkg::*;

	typedef struct packed {
		logic [2:0]        status;
		logic [5:0]        index;
		logic [TICK_W-1:0] expiry;
		logic              last;
	} result_t;

	class timer_scoreboard;
		logic [TICK_W-1:0] expiry_tab [NUM_TIMERS];
		logic [6:0]        link_tab [NUM_TIMERS];
		bit                owned [NUM_TIMERS];
		int                head, mark;
		logic [TICK_W-1:0] now, soonest;
		result_t           pending [$];
		int                mismatches;
		int                checked;
		int                expired_seen;

		function void clear_table();
			for (int i = 0; i < NUM_TIMERS; i++) begin
				expiry_tab[i] = '0;
				link_tab[i] = 7'(i + 1);
				owned[i] = 0;
			end
			head = 0;
			mark = 0;
			now = '0;
			soonest = TICK_NONE;
		endfunction

		function void push(status_t st, int idx, logic [TICK_W-1:0] e, bit lst);
			result_t r;
			r.status = st;
			r.index = 6'(idx);
			r.expiry = e;
			r.last = lst;
			pending.push_back(r);
		endfunction

		function status_t write_slot(int idx, logic [TICK_W-1:0] v, bit want_active);
			if (idx >= mark)
				return ST_BAD_INDEX;
			if ((expiry_tab[idx] != TICK_NONE) != want_active)
				return ST_WRONG_STATE;
			expiry_tab[idx] = v;
			if (v != TICK_NONE && v < soonest)
				soonest = v;
			return ST_OK;
		endfunction

		function void note_command(logic [2:0] md, int idx, logic [TICK_W-1:0] t);
			status_t st;
			int slot, n;
			logic [TICK_W-1:0] next_soon;
			case (md)
				MODE_TICK: begin
					if (t == TICK_NONE) st = ST_BAD_TICK;
					else if (t <= now) st = ST_TICK_IGNORED;
					else begin
						now = t;
						st = ST_OK;
					end
					push(st, 0, '0, 1);
				end
				MODE_ALLOC: begin
					slot = head;
					if (slot >= NUM_TIMERS) push(ST_NONE_FREE, 0, '0, 1);
					else begin
						head = link_tab[slot];
						expiry_tab[slot] = TICK_NONE;
						owned[slot] = 1;
						if (slot + 1 > mark) mark = slot + 1;
						push(ST_OK, slot, '0, 1);
					end
				end
				MODE_FREE: begin
					if (idx >= mark) st = ST_BAD_INDEX;
					else if (!owned[idx] || expiry_tab[idx] != TICK_NONE) st = ST_WRONG_STATE;
					else begin
						link_tab[idx] = 7'(head);
						head = idx;
						owned[idx] = 0;
						st = ST_OK;
					end
					push(st, 0, '0, 1);
				end
				MODE_ARM, MODE_REARM: begin
					if (t == TICK_NONE) st = ST_BAD_TICK;
					else st = write_slot(idx, t, md == MODE_REARM);
					push(st, 0, '0, 1);
				end
				MODE_CANCEL: push(write_slot(idx, TICK_NONE, 1), 0, '0, 1);
				MODE_EXPIRE: begin
					if (soonest > now) push(ST_NONE_DUE, 0, '0, 1);
					else begin
						n = 0;
						next_soon = TICK_NONE;
						for (int i = 0; i < mark; i++) begin
							if (expiry_tab[i] <= now) begin
								push(ST_EXPIRED, i, expiry_tab[i], 0);
								expiry_tab[i] = TICK_NONE;
								n++;
							end else if (expiry_tab[i] < next_soon)
								next_soon = expiry_tab[i];
						end
						soonest = next_soon;
						if (n == 0) push(ST_NONE_DUE, 0, '0, 1);
						else pending[$].last = 1;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(result_t got);
			result_t want;
			checked++;
			if (got.status == ST_EXPIRED) expired_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result st=%0d idx=%0d exp=%h last=%0d",
						got.status, got.index, got.expiry, got.last);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: want st=%0d idx=%0d exp=%h last=%0d, got st=%0d idx=%0d exp=%h last=%0d",
						want.status, want.index, want.expiry, want.last,
						got.status, got.index, got.expiry, got.last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	tte_in_if  req ();
	tte_out_if rsp ();

	timer_table_engine dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	timer_scoreboard sb;
	bit   hold_off;
	bit   stim_done;
	int   idle_cycles = 0;
	int   burst_left;
	logic [TICK_W-1:0] tick_base;

	initial clk = 0;
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Send one item, keeping valid high across back-to-back items in a burst.
	task automatic send(logic [2:0] md, logic [5:0] idx, logic [TICK_W-1:0] t);
		if (burst_left == 0) begin
			req.valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) == 0) burst_left = 40;
		end
		req.valid <= 1;
		req.mode <= md;
		req.timer_index <= idx;
		req.tick_value <= t;
		do @(posedge clk); while (!req.ready);
		sb.note_command(md, idx, t);
		burst_left--;
	endtask

	function automatic logic [TICK_W-1:0] near_tick();
		return tick_base + $urandom_range(0, 40);
	endfunction

	// Receiver: stall pattern plus a long hold-off when asked.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 0;
		end else begin
			if (rsp.valid && rsp.ready)
				sb.check_result('{rsp.status, rsp.timer_index_out, rsp.expiry_out, rsp.last});
			rsp.ready <= !hold_off && ($urandom_range(0, 9) < 7 || stim_done);
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		hold_off = 1;
		repeat (400) @(posedge clk);
		hold_off = 0;
	end

	initial begin
		logic [2:0] md;
		int r;
		sb = new();
		sb.clear_table();
		stim_done = 0;
		burst_left = 0;
		tick_base = 64'd100;
		req.valid = 0;
		req.mode = MODE_TICK;
		req.timer_index = '0;
		req.tick_value = '0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: errors on an empty table, then a small working set.
		send(MODE_FREE, 0, 0);
		send(MODE_ARM, 63, 5);
		send(MODE_EXPIRE, 0, 0);
		send(MODE_TICK, 0, TICK_NONE);
		send(MODE_TICK, 0, 0);
		send(MODE_TICK, 0, 64'd100);
		send(MODE_ALLOC, 0, 0);
		send(MODE_ALLOC, 0, 0);
		send(MODE_ARM, 0, TICK_NONE);
		send(MODE_ARM, 0, 64'd50);
		send(MODE_ARM, 0, 64'd60);
		send(MODE_REARM, 1, 64'd70);
		send(MODE_REARM, 0, 64'd90);
		send(MODE_FREE, 0, 0);
		send(MODE_ARM, 1, 64'hFFFF_FFFF_FFFF_FFFE);
		send(MODE_CANCEL, 1, 0);
		send(MODE_CANCEL, 1, 0);
		send(MODE_NONE, 63, TICK_NONE);
		send(MODE_EXPIRE, 0, 0);
		send(MODE_EXPIRE, 0, 0);
		send(MODE_FREE, 1, 0);
		send(MODE_FREE, 1, 0);
		send(MODE_ALLOC, 0, 0);
		// Fill the table so the free list runs dry.
		for (int i = 0; i < 64; i++) send(MODE_ALLOC, 0, 0);

		for (int n = 0; n < 130; n++) begin
			r = $urandom_range(0, 99);
			if (r < 30) md = MODE_ARM;
			else if (r < 40) md = MODE_REARM;
			else if (r < 48) md = MODE_CANCEL;
			else if (r < 58) md = MODE_EXPIRE;
			else if (r < 70) md = MODE_TICK;
			else if (r < 80) md = MODE_FREE;
			else if (r < 92) md = MODE_ALLOC;
			else md = 3'($urandom_range(0, 7));
			if (md == MODE_TICK && $urandom_range(0, 9) > 0)
				tick_base = tick_base + $urandom_range(1, 30);
			if ($urandom_range(0, 19) == 0)
				send(md, 6'($urandom_range(0, 63)), {$urandom, $urandom});
			else
				send(md, 6'($urandom_range(0, 63)),
					md == MODE_TICK ? tick_base : near_tick());
		end
		// Late time jump so everything armed comes due.
		send(MODE_TICK, 0, 64'hFFFF_FFFF_FFFF_FFFE);
		send(MODE_EXPIRE, 0, 0);
		send(MODE_EXPIRE, 0, 0);
		req.valid <= 0;
		stim_done = 1;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Ran %0d results, %0d expiry reports, over all modes and error cases.",
			sb.checked, sb.expired_seen);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ===== files.f =====
src/tte_pkg.sv
src/tte_in_if.sv
src/tte_out_if.sv
src/tte_ram.sv
src/timer_table_engine.sv
bench/timer_table_engine_tb.sv
